// File: hw/rtl/pit_pkg.sv
`timescale 1ns / 1ps

package pit_pkg;

   localparam int BASE_CLOCK_HZ = 1193182;
   localparam int US_PER_SECOND = 1000000;
   localparam int DIV_W         = 21;
   localparam int NOW_W         = 63;
   localparam int TS_W          = 64;
   localparam int CNT_W         = 16;
   localparam logic [1:0] CMD_PORT = 2'd3;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TIME  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_LATCH = 2'd0,
      MODE_LOW   = 2'd1,
      MODE_HIGH  = 2'd2,
      MODE_LOHI  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAIT_Q,
      ST_WAIT_P,
      ST_COUNT,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_CAPTURE,
      DP_PORT,
      DP_FREEZE_SYNC,
      DP_DIV_Q,
      DP_DIV_P,
      DP_IRQ_CHECK,
      DP_COUNT,
      DP_LOAD_RSP
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   freeze;
      logic   ch0_en;
      logic   div_done;
   } dp_status_type;

endpackage

// File: hw/rtl/pit_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module pit_div #(
   parameter int W = 21
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quotient
);

   localparam int CW = $clog2(W);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  div_ff, div_in;
   logic [W:0]    trial;

   assign trial = {rem_ff, quo_ff[W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, div_ff}) begin
            rem_in = W'(trial - {1'b0, div_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         if (cnt_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = CW'(cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/pit_dp.sv
`timescale 1ns / 1ps

module pit_dp #(
   parameter int NUM_CHANNELS = 3,
   parameter int COUNT_STEP   = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pit_pkg::dp_cmd_type   cmd,
   input  logic [79:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_data,
   output pit_pkg::dp_status_type status,
   output logic [15:0]           rsp_tdata
);

   localparam int INTERVAL =
      pit_pkg::US_PER_SECOND / (pit_pkg::BASE_CLOCK_HZ / COUNT_STEP);
   localparam logic [pit_pkg::TS_W-1:0]  INTERVAL_TS = pit_pkg::TS_W'(INTERVAL);
   localparam logic [pit_pkg::CNT_W-1:0] STEP        = pit_pkg::CNT_W'(COUNT_STEP);

   logic                 en_ff     [NUM_CHANNELS];
   logic                 en_in     [NUM_CHANNELS];
   logic                 tog_ff    [NUM_CHANNELS];
   logic                 tog_in    [NUM_CHANNELS];
   pit_pkg::mode_type    mode_ff   [NUM_CHANNELS];
   pit_pkg::mode_type    mode_in   [NUM_CHANNELS];
   logic [15:0]          reload_ff [NUM_CHANNELS];
   logic [15:0]          reload_in [NUM_CHANNELS];
   logic [15:0]          count_ff  [NUM_CHANNELS];
   logic [15:0]          count_in  [NUM_CHANNELS];

   logic [pit_pkg::TS_W-1:0]  last_irq_ff, last_irq_in;
   logic [pit_pkg::TS_W-1:0]  last_cnt_ff, last_cnt_in;
   logic                      freeze_ff, freeze_in;

   pit_pkg::op_type           op_ff, op_in;
   logic [1:0]                port_ff, port_in;
   logic [7:0]                data_ff, data_in;
   logic [pit_pkg::NOW_W-1:0] now_ff, now_in;
   logic [7:0]                rd_ff, rd_in;
   logic                      irq_ff, irq_in;
   logic [15:0]               rsp_data_ff, rsp_data_in;

   logic [pit_pkg::TS_W-1:0]  now_ts;
   logic [16:0]               divisor0;
   logic                      div_start;
   logic [pit_pkg::DIV_W-1:0] div_dividend;
   logic [pit_pkg::DIV_W-1:0] div_divisor;
   logic [pit_pkg::DIV_W-1:0] div_quot;
   logic                      div_done;
   pit_pkg::mode_type         cmd_mode;

   assign now_ts   = {1'b0, now_ff};
   assign divisor0 = (reload_ff[0] == 16'd0) ? 17'h10000 : {1'b0, reload_ff[0]};
   assign cmd_mode = pit_pkg::mode_type'(data_ff[5:4]);

   // period = 1000000 / (1193182 / divisor), two passes through one divider
   assign div_start    = (cmd == pit_pkg::DP_DIV_Q) || (cmd == pit_pkg::DP_DIV_P);
   assign div_dividend = (cmd == pit_pkg::DP_DIV_Q) ?
                         pit_pkg::DIV_W'(pit_pkg::BASE_CLOCK_HZ) :
                         pit_pkg::DIV_W'(pit_pkg::US_PER_SECOND);
   assign div_divisor  = (cmd == pit_pkg::DP_DIV_Q) ?
                         pit_pkg::DIV_W'(divisor0) : div_quot;

   pit_div #(
      .W (pit_pkg::DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      en_in       = en_ff;
      tog_in      = tog_ff;
      mode_in     = mode_ff;
      reload_in   = reload_ff;
      count_in    = count_ff;
      last_irq_in = last_irq_ff;
      last_cnt_in = last_cnt_ff;
      freeze_in   = freeze_ff;
      op_in       = op_ff;
      port_in     = port_ff;
      data_in     = data_ff;
      now_in      = now_ff;
      rd_in       = rd_ff;
      irq_in      = irq_ff;
      rsp_data_in = rsp_data_ff;

      if (csr_valid) begin
         freeze_in = csr_data;
      end

      case (cmd)
         pit_pkg::DP_CAPTURE: begin
            op_in   = pit_pkg::op_type'(req_tuser);
            port_in = req_tdata[1:0];
            data_in = req_tdata[9:2];
            now_in  = req_tdata[72:10];
            rd_in   = 8'd0;
            irq_in  = 1'b0;
         end
         pit_pkg::DP_PORT: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (op_ff == pit_pkg::OP_READ && port_ff == 2'(i)) begin
                  if (mode_ff[i] == pit_pkg::MODE_HIGH ||
                      (mode_ff[i] == pit_pkg::MODE_LOHI && tog_ff[i])) begin
                     rd_in = count_ff[i][15:8];
                  end else begin
                     rd_in = count_ff[i][7:0];
                  end
                  if (mode_ff[i] == pit_pkg::MODE_LATCH ||
                      mode_ff[i] == pit_pkg::MODE_LOHI) begin
                     tog_in[i] = !tog_ff[i];
                  end
               end
               if (op_ff == pit_pkg::OP_WRITE && port_ff == pit_pkg::CMD_PORT &&
                   data_ff[7:6] == 2'(i)) begin
                  mode_in[i] = cmd_mode;
                  if (cmd_mode == pit_pkg::MODE_LOHI) begin
                     tog_in[i] = 1'b0;
                  end
               end
               if (op_ff == pit_pkg::OP_WRITE && port_ff == 2'(i)) begin
                  en_in[i] = 1'b1;
                  case (mode_ff[i])
                     pit_pkg::MODE_LOW: begin
                        reload_in[i] = {reload_ff[i][15:8], data_ff};
                     end
                     pit_pkg::MODE_HIGH: begin
                        reload_in[i] = {data_ff, reload_ff[i][7:0]};
                     end
                     pit_pkg::MODE_LOHI: begin
                        if (tog_ff[i]) begin
                           reload_in[i] = {data_ff, reload_ff[i][7:0]};
                        end else begin
                           reload_in[i] = {reload_ff[i][15:8], data_ff};
                        end
                        tog_in[i] = !tog_ff[i];
                     end
                     default: ;
                  endcase
               end
            end
         end
         pit_pkg::DP_FREEZE_SYNC: begin
            last_irq_in = now_ts;
            last_cnt_in = now_ts;
         end
         pit_pkg::DP_IRQ_CHECK: begin
            if (now_ts >= last_irq_ff + pit_pkg::TS_W'(div_quot)) begin
               last_irq_in = now_ts;
               irq_in      = 1'b1;
            end
         end
         pit_pkg::DP_COUNT: begin
            if (now_ts >= last_cnt_ff + INTERVAL_TS) begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (en_ff[i]) begin
                     if (count_ff[i] < STEP) begin
                        count_in[i] = reload_ff[i];
                     end else begin
                        count_in[i] = count_ff[i] - STEP;
                     end
                  end
               end
               last_cnt_in = now_ts;
            end
         end
         pit_pkg::DP_LOAD_RSP: begin
            rsp_data_in = {7'd0, irq_ff, rd_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            en_ff[i]     <= 1'b0;
            tog_ff[i]    <= 1'b0;
            mode_ff[i]   <= pit_pkg::MODE_LATCH;
            reload_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
         last_irq_ff <= '0;
         last_cnt_ff <= '0;
         freeze_ff   <= 1'b0;
      end else begin
         en_ff       <= en_in;
         tog_ff      <= tog_in;
         mode_ff     <= mode_in;
         reload_ff   <= reload_in;
         count_ff    <= count_in;
         last_irq_ff <= last_irq_in;
         last_cnt_ff <= last_cnt_in;
         freeze_ff   <= freeze_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      port_ff     <= port_in;
      data_ff     <= data_in;
      now_ff      <= now_in;
      rd_ff       <= rd_in;
      irq_ff      <= irq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.op       = op_ff;
   assign status.freeze   = freeze_ff;
   assign status.ch0_en   = en_ff[0];
   assign status.div_done = div_done;
   assign rsp_tdata       = rsp_data_ff;

endmodule

// File: hw/rtl/pit_ctrl.sv
`timescale 1ns / 1ps

module pit_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  pit_pkg::dp_status_type status,
   output pit_pkg::dp_cmd_type   cmd
);

   pit_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pit_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = pit_pkg::DP_NONE;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         pit_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd      = pit_pkg::DP_CAPTURE;
               state_in = pit_pkg::ST_EXEC;
            end
         end
         pit_pkg::ST_EXEC: begin
            case (status.op)
               pit_pkg::OP_READ, pit_pkg::OP_WRITE: begin
                  cmd      = pit_pkg::DP_PORT;
                  state_in = pit_pkg::ST_RESP;
               end
               pit_pkg::OP_TIME: begin
                  if (status.freeze) begin
                     cmd      = pit_pkg::DP_FREEZE_SYNC;
                     state_in = pit_pkg::ST_RESP;
                  end else if (status.ch0_en) begin
                     cmd      = pit_pkg::DP_DIV_Q;
                     state_in = pit_pkg::ST_WAIT_Q;
                  end else begin
                     state_in = pit_pkg::ST_COUNT;
                  end
               end
               default: begin
                  state_in = pit_pkg::ST_RESP;
               end
            endcase
         end
         pit_pkg::ST_WAIT_Q: begin
            if (status.div_done) begin
               cmd      = pit_pkg::DP_DIV_P;
               state_in = pit_pkg::ST_WAIT_P;
            end
         end
         pit_pkg::ST_WAIT_P: begin
            if (status.div_done) begin
               cmd      = pit_pkg::DP_IRQ_CHECK;
               state_in = pit_pkg::ST_COUNT;
            end
         end
         pit_pkg::ST_COUNT: begin
            cmd      = pit_pkg::DP_COUNT;
            state_in = pit_pkg::ST_RESP;
         end
         pit_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd          = pit_pkg::DP_LOAD_RSP;
               rsp_valid_in = 1'b1;
               state_in     = pit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pit_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: hw/rtl/programmable_interval_timer_3ch_unit.sv
`timescale 1ns / 1ps

// Three-channel interval timer behind a four-port byte interface.
// Each request on req_* is a port read, a port write, a time update or a no-op
// (kind on req_tuser); every request returns exactly one response on rsp_*
// carrying the read byte and the channel 0 interrupt flag.
// csr_* writes the debug freeze bit; it is always ready and should be
// written only while no request is outstanding.
// One request is handled at a time. Port reads and writes run the port step
// and frozen time updates resync both timestamps before the response state;
// no-op requests go straight to it. A time update without channel 0 enabled
// runs the count step; with channel 0 enabled it first runs two passes of a
// 21-bit bit-serial divider for the interrupt period and the interrupt check.
// The next request is accepted the cycle after the response is loaded.
// A response that is not taken holds the next one back in its final state.
// Synchronous reset clears all channels (disabled, latch mode, zero counts),
// both timestamps and the freeze bit, and leaves no response pending.
module programmable_interval_timer_3ch_unit #(
   parameter int NUM_CHANNELS = 3,
   parameter int COUNT_STEP   = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // port_offset[1:0], write_data[9:2], now_us[72:10]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], irq[8]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   pit_pkg::dp_cmd_type    cmd;
   pit_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   pit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pit_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .COUNT_STEP   (COUNT_STEP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_CH       = 3;
   localparam int STEP         = 10;
   localparam int TICK_US      =
      pit_pkg::US_PER_SECOND / (pit_pkg::BASE_CLOCK_HZ / STEP);
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int LONG_STALL   = 400;
   localparam int SETTLE_WAIT  = 60;
   localparam logic [62:0] NOW_MAX = {63{1'b1}};

   typedef struct packed {
      pit_pkg::op_type op;
      logic [1:0]      port;
      logic [7:0]      data;
      logic [62:0]     now;
   } request_type;

   typedef struct packed {
      logic [7:0] rd;
      logic       irq;
   } reply_type;

   typedef struct {
      request_type req;
      bit          typed;
      reply_type   want;
   } step_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   // timer state mirror
   logic              ch_en     [NUM_CH];
   logic              ch_flip   [NUM_CH];
   pit_pkg::mode_type ch_mode   [NUM_CH];
   logic [15:0]       ch_reload [NUM_CH];
   logic [15:0]       ch_count  [NUM_CH];
   logic [63:0]       irq_stamp;
   logic [63:0]       tick_stamp;
   logic              freeze_q;

   reply_type    pit_replies [$];
   step_row_type directed_rows [$];
   logic [62:0]  time_base;
   int          src_idle_pct  = 0;
   int          sink_idle_pct = 0;
   int          hold_requests = 0;
   int          holds_served  = 0;
   int          stall_left    = 0;
   int          error_count   = 0;
   int          requests_sent = 0;
   int          replies_seen  = 0;
   int          irq_seen      = 0;
   int          frozen_updates = 0;
   int          cycle_count   = 0;

   always #4 clock = ~clock;

   programmable_interval_timer_3ch_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   function automatic void pit_clear();
      int i;
      for (i = 0; i < NUM_CH; i++) begin
         ch_en[i]     = 1'b0;
         ch_flip[i]   = 1'b0;
         ch_mode[i]   = pit_pkg::MODE_LATCH;
         ch_reload[i] = '0;
         ch_count[i]  = '0;
      end
      irq_stamp  = '0;
      tick_stamp = '0;
      freeze_q   = 1'b0;
   endfunction

   function automatic reply_type pit_predict(request_type r);
      reply_type         res;
      int                idx;
      int                i;
      pit_pkg::mode_type m;
      logic [1:0]        sel;
      int unsigned       divisor;
      int unsigned       rate;
      int unsigned       period;
      logic [63:0]       now64;
      res   = '0;
      idx   = r.port;
      now64 = {1'b0, r.now};
      case (r.op)
         pit_pkg::OP_READ: begin
            if (r.port != pit_pkg::CMD_PORT) begin
               m = ch_mode[idx];
               if (m == pit_pkg::MODE_HIGH || (m == pit_pkg::MODE_LOHI && ch_flip[idx]))
                  res.rd = ch_count[idx][15:8];
               else
                  res.rd = ch_count[idx][7:0];
               if (m == pit_pkg::MODE_LATCH || m == pit_pkg::MODE_LOHI)
                  ch_flip[idx] = !ch_flip[idx];
            end
         end
         pit_pkg::OP_WRITE: begin
            if (r.port == pit_pkg::CMD_PORT) begin
               sel = r.data[7:6];
               if (sel < NUM_CH) begin
                  ch_mode[sel] = pit_pkg::mode_type'(r.data[5:4]);
                  if (ch_mode[sel] == pit_pkg::MODE_LOHI)
                     ch_flip[sel] = 1'b0;
               end
            end else begin
               ch_en[idx] = 1'b1;
               m = ch_mode[idx];
               if (m == pit_pkg::MODE_LOW || (m == pit_pkg::MODE_LOHI && !ch_flip[idx]))
                  ch_reload[idx][7:0] = r.data;
               else if (m == pit_pkg::MODE_HIGH ||
                        (m == pit_pkg::MODE_LOHI && ch_flip[idx]))
                  ch_reload[idx][15:8] = r.data;
               if (m == pit_pkg::MODE_LOHI)
                  ch_flip[idx] = !ch_flip[idx];
            end
         end
         pit_pkg::OP_TIME: begin
            if (freeze_q) begin
               irq_stamp  = now64;
               tick_stamp = now64;
            end else begin
               if (ch_en[0]) begin
                  divisor = (ch_reload[0] == 16'd0) ? 32'd65536 : 32'(ch_reload[0]);
                  rate    = pit_pkg::BASE_CLOCK_HZ / divisor;
                  period  = pit_pkg::US_PER_SECOND / rate;
                  if (now64 >= irq_stamp + 64'(period)) begin
                     irq_stamp = now64;
                     res.irq   = 1'b1;
                  end
               end
               if (now64 >= tick_stamp + 64'(TICK_US)) begin
                  for (i = 0; i < NUM_CH; i++) begin
                     if (ch_en[i]) begin
                        if (ch_count[i] < 16'(STEP))
                           ch_count[i] = ch_reload[i];
                        else
                           ch_count[i] = ch_count[i] - 16'(STEP);
                     end
                  end
                  tick_stamp = now64;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int          pick;
      r.op   = pit_pkg::OP_NONE;
      r.now  = 63'({$urandom, $urandom});
      r.data = 8'($urandom);
      r.port = 2'($urandom);
      pick   = $urandom_range(99);
      if (pick < 22) begin
         r.op   = pit_pkg::OP_WRITE;
         r.port = pit_pkg::CMD_PORT;
         r.data[7:6] = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      end else if (pick < 48) begin
         r.op   = pit_pkg::OP_WRITE;
         r.port = 2'($urandom_range(2));
      end else if (pick < 70) begin
         r.op   = pit_pkg::OP_READ;
         r.port = ($urandom_range(19) == 0) ? pit_pkg::CMD_PORT : 2'($urandom_range(2));
      end else if (pick < 97) begin
         r.op = pit_pkg::OP_TIME;
         pick = $urandom_range(99);
         if (pick < 3 && time_base > 63'd1000)
            time_base = time_base - 63'($urandom_range(1000));
         else if (pick < 4)
            time_base = time_base + (63'({$urandom, $urandom}) >> 8);
         else if (pick < 50)
            time_base = time_base + 63'($urandom_range(15));
         else if (pick < 80)
            time_base = time_base + 63'($urandom_range(1000));
         else
            time_base = time_base + 63'($urandom_range(70000));
         r.now = time_base;
      end
      return r;
   endfunction

   function automatic void add_row(pit_pkg::op_type op, logic [1:0] port, logic [7:0] data,
                                   logic [62:0] now, bit typed, logic [7:0] rd, logic irq);
      step_row_type row;
      row.req   = '{op: op, port: port, data: data, now: now};
      row.typed = typed;
      row.want  = '{rd: rd, irq: irq};
      directed_rows.push_back(row);
   endfunction

   task automatic issue(input request_type r, input bit typed, input reply_type want);
      reply_type model;
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, r.now, r.data, r.port};
      req_tuser  <= r.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = pit_predict(r);
      if (r.op == pit_pkg::OP_TIME && freeze_q)
         frozen_updates++;
      pit_replies.push_back(typed ? want : model);
      requests_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pit_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_freeze(input logic value);
      drain();
      repeat (SETTLE_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      freeze_q = value;
   endtask

   task automatic run_random(input int count, input int src_pct, input int sink_pct,
                             input logic freeze);
      int i;
      write_freeze(freeze);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
      for (i = 0; i < count; i++) begin
         if (i == count / 3)
            drain();
         if (i == count / 2)
            hold_requests++;
         issue(random_request(), 1'b0, '0);
      end
   endtask

   // response side: checking and backpressure
   always @(posedge clock) begin : reply_sink
      reply_type got;
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.rd  = rsp_tdata[7:0];
         got.irq = rsp_tdata[8];
         replies_seen++;
         if (got.irq)
            irq_seen++;
         if (pit_replies.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response: read_data=%h irq=%b", got.rd, got.irq);
         end else begin
            want = pit_replies.pop_front();
            if (got.rd !== want.rd || got.irq !== want.irq) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch on response %0d: read_data exp %h got %h, irq exp %b got %b",
                           replies_seen, want.rd, got.rd, want.irq, got.irq);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         stall_left = LONG_STALL;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      pit_clear();
      time_base = '0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset values, command port, ignored select, all modes
      add_row(pit_pkg::OP_READ,  2'd0, 8'h00, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_READ,  2'd2, 8'h00, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_READ,  pit_pkg::CMD_PORT, 8'hFF, NOW_MAX, 1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_TIME,  2'd0, 8'h00, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_NONE,  pit_pkg::CMD_PORT, 8'hFF, NOW_MAX, 1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, pit_pkg::CMD_PORT, 8'h30, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd0, 8'h00, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd0, 8'h00, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, pit_pkg::CMD_PORT, 8'hFF, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, pit_pkg::CMD_PORT, 8'h50, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd1, 8'hFF, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, pit_pkg::CMD_PORT, 8'h60, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd1, 8'hFF, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, pit_pkg::CMD_PORT, 8'h80, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd2, 8'hAB, 63'd0,   1, 8'h00, 1'b0);
      add_row(pit_pkg::OP_TIME,  2'd0, 8'h00, 63'd8,     0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_TIME,  2'd0, 8'h00, 63'd7,     0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_TIME,  2'd0, 8'h00, 63'd55555, 0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_READ,  2'd1, 8'h00, 63'd0,   0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_READ,  2'd2, 8'h00, 63'd0,   0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_READ,  2'd2, 8'h00, 63'd0,   0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_READ,  2'd0, 8'h00, 63'd0,   0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd0, 8'h01, 63'd0,   0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_WRITE, 2'd0, 8'h00, 63'd0,   0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_TIME,  2'd0, 8'h00, NOW_MAX, 0, 8'h00, 1'b0);
      add_row(pit_pkg::OP_TIME,  2'd0, 8'h00, 63'd0,   0, 8'h00, 1'b0);
      foreach (directed_rows[i])
         issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // frozen phase first so the timestamps resync after the directed jump to max
      run_random(150, 15, 76, 1'b1);
      run_random(600, 15, 76, 1'b0);
      run_random(600, 76, 15, 1'b0);
      run_random(550, 0, 0, 1'b0);

      drain();
      repeat (100) @(posedge clock);
      $display("%0d requests checked, %0d interrupts, %0d frozen time updates, %0d long stalls",
               requests_sent, irq_seen, frozen_updates, holds_served);
      $display("idling mixes: sender-heavy, receiver-heavy and none; freeze set and cleared");
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
